// ===== sv/sid_pkg.sv =====
package sid_pkg;

    // default operand width
    localparam int DATA_WIDTH_DEF = 32;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_DIV0 = 2'd1,
        STATUS_OVF  = 2'd2
    } sid_status_t;

    // controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIX  = 3'b100
    } sid_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;    // capture operands and classify
        logic step;    // one restoring iteration
        logic finish;  // sign fix and write output register
    } sid_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic special;   // divide by zero or overflow, no iteration needed
        logic out_free;  // output register can take a word this cycle
    } sid_stat_t;

endpackage

// ===== sv/sid_if.sv =====
interface sid_in_if #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] numerator;
    logic signed [DATA_WIDTH-1:0] denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface sid_out_if #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quotient;
    logic [1:0]                   status;

    modport source (output valid, output quotient, output status, input ready);
    modport sink   (input valid, input quotient, input status, output ready);
endinterface

// ===== sv/sid_ctrl.sv =====
module sid_ctrl #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sid_pkg::sid_stat_t stat,
    output sid_pkg::sid_cmd_t  cmd
);
    import sid_pkg::*;

    localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    sid_state_t    state_reg;
    sid_state_t    state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = CW'(DATA_WIDTH - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.special)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_FIX;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            ST_FIX:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // checks
    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_DIV)
        else $error("load did not start division");

    a_last_step_to_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && cnt_reg == '0) |=> state_reg == ST_FIX)
        else $error("last iteration did not reach fix-up");

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == ST_IDLE && in_ready))
        else $error("finish did not return to idle");

endmodule

// ===== sv/sid_dp.sv =====
module sid_dp #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sid_pkg::sid_cmd_t            cmd,
    output sid_pkg::sid_stat_t           stat,
    input  logic signed [DATA_WIDTH-1:0] numerator,
    input  logic signed [DATA_WIDTH-1:0] denominator,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output logic [1:0]                   status
);
    import sid_pkg::*;

    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] ONE     = DATA_WIDTH'(1);

    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] div_reg;
    logic                  neg_reg;
    logic                  special_reg;
    sid_status_t           st_reg;

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_quo_reg;
    sid_status_t           out_st_reg;

    logic [DATA_WIDTH-1:0] num_u;
    logic [DATA_WIDTH-1:0] den_u;
    logic [DATA_WIDTH-1:0] num_mag;
    logic [DATA_WIDTH-1:0] den_mag;
    logic                  is_div0;
    logic                  is_ovf;
    logic [DATA_WIDTH-1:0] rem_shift;
    logic [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH-1:0] result;

    // operand magnitudes and special cases
    always_comb
    begin
        num_u   = numerator;
        den_u   = denominator;
        num_mag = num_u[DATA_WIDTH-1] ? (~num_u + ONE) : num_u;
        den_mag = den_u[DATA_WIDTH-1] ? (~den_u + ONE) : den_u;
        is_div0 = (den_u == '0);
        is_ovf  = (num_u == MIN_VAL) && (den_u == '1);
    end

    // one restoring iteration
    always_comb
    begin
        rem_shift = {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};
        diff      = {1'b0, rem_shift} - {1'b0, div_reg};
    end

    // sign fix-up or special value
    always_comb
    begin
        if (special_reg)
        begin
            result = (st_reg == STATUS_DIV0) ? MIN_VAL : MAX_VAL;
        end
        else
        begin
            result = neg_reg ? (~quo_reg + ONE) : quo_reg;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg     <= '0;
            quo_reg     <= num_mag;
            div_reg     <= den_mag;
            neg_reg     <= num_u[DATA_WIDTH-1] ^ den_u[DATA_WIDTH-1];
            special_reg <= is_div0 | is_ovf;
            priority if (is_div0)
            begin
                st_reg <= STATUS_DIV0;
            end
            else if (is_ovf)
            begin
                st_reg <= STATUS_OVF;
            end
            else
            begin
                st_reg <= STATUS_OK;
            end
        end
        else if (cmd.step)
        begin
            if (!diff[DATA_WIDTH])
            begin
                rem_reg <= diff[DATA_WIDTH-1:0];
            end
            else
            begin
                rem_reg <= rem_shift;
            end
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_quo_reg <= result;
            out_st_reg  <= st_reg;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.special  = special_reg;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign quotient      = out_quo_reg;
    assign status        = out_st_reg;

    // checks
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> rem_reg < div_reg)
        else $error("partial remainder not below divisor");

    a_div0_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_st_reg == STATUS_DIV0) |-> out_quo_reg == MIN_VAL)
        else $error("divide by zero word carries wrong quotient");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished word not presented");

endmodule

// ===== sv/signed_integer_divider.sv =====
// Signed divider: quotient of numerator by denominator, truncated toward zero,
// with status ok, divide by zero (quotient = most negative value) or overflow
// (most negative over minus one, quotient = largest positive value). A word is
// accepted only while the block is idle; it then takes a load step, DATA_WIDTH
// iterations of a single restoring subtract-and-shift unit (one quotient bit
// per cycle) and a sign fix-up step that writes the output register, and only
// then returns to idle for the next word; the fix-up step waits while the
// output register is full and not being read. Divide-by-zero and overflow skip
// the iterations. The output register lets the next word be accepted while a
// result still waits to be taken.
module signed_integer_divider #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
    input logic clk,
    input logic rst_n,
    sid_in_if.sink    req,
    sid_out_if.source rsp
);
    import sid_pkg::*;

    sid_cmd_t  cmd;
    sid_stat_t stat;

    sid_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sid_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .numerator   (req.numerator),
        .denominator (req.denominator),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .quotient    (rsp.quotient),
        .status      (rsp.status)
    );

endmodule

// ===== test/tb_signed_integer_divider.sv =====
`timescale 1ns / 1ps

module tb_signed_integer_divider;

    import sid_pkg::*;

    localparam int DW          = 32;
    localparam int STALL_LIMIT = 3000;  // cycles with no word moving on either side
    localparam int HOLD_CYCLES = 400;   // long output back-pressure stretch
    localparam int DRAIN_WAIT  = 40;    // settle time once nothing is outstanding
    localparam int RAND_WORDS  = 500;   // per random phase

    localparam logic [DW-1:0] MOST_NEG  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS  = ~MOST_NEG;
    localparam logic [DW-1:0] MINUS_ONE = '1;

    typedef struct packed {
        logic [DW-1:0] num;
        logic [DW-1:0] den;
    } div_word_t;

    typedef struct packed {
        logic [DW-1:0] quotient;
        sid_status_t   status;
    } div_result_t;

    logic clk = 1'b0;
    logic rst_n;

    sid_in_if  #(.DATA_WIDTH(DW)) req_if ();
    sid_out_if #(.DATA_WIDTH(DW)) rsp_if ();

    signed_integer_divider #(
        .DATA_WIDTH (DW)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    div_word_t   pending_q[$];
    div_result_t quotient_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent    = 0;
    int fail_cnt      = 0;
    int idle_cycles   = 0;
    int hold_cnt      = 0;
    bit hold_done     = 1'b0;

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // expected quotient and status, truncated toward zero on magnitudes
    function automatic div_result_t predict_quotient(logic [DW-1:0] num, logic [DW-1:0] den);
        div_result_t   res;
        logic [DW-1:0] num_mag;
        logic [DW-1:0] den_mag;
        logic [DW-1:0] q_mag;
        if (den == '0)
        begin
            res.quotient = MOST_NEG;
            res.status   = STATUS_DIV0;
        end
        else if (num == MOST_NEG && den == MINUS_ONE)
        begin
            res.quotient = MOST_POS;
            res.status   = STATUS_OVF;
        end
        else
        begin
            // magnitude of the most negative value stays correct as unsigned
            num_mag = num[DW-1] ? -num : num;
            den_mag = den[DW-1] ? -den : den;
            q_mag   = num_mag / den_mag;
            res.quotient = (num[DW-1] ^ den[DW-1]) ? -q_mag : q_mag;
            res.status   = STATUS_OK;
        end
        return res;
    endfunction

    function automatic logic [DW-1:0] rand_operand();
        logic [DW-1:0] mag;
        logic [DW-1:0] val;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                val = $urandom;
            end
            2, 3:
            begin
                mag = $urandom >> $urandom_range(0, DW - 1);
                val = $urandom_range(0, 1) ? -mag : mag;
            end
            4:
            begin
                mag = $urandom_range(0, 20);
                val = $urandom_range(0, 1) ? -mag : mag;
            end
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       val = MOST_NEG;
                    1:       val = MOST_POS;
                    2:       val = MINUS_ONE;
                    3:       val = 1;
                    default: val = MOST_NEG + 1;
                endcase
            end
        endcase
        return val;
    endfunction

    task automatic push_word(logic [DW-1:0] num, logic [DW-1:0] den);
        div_word_t w;
        w.num = num;
        w.den = den;
        pending_q.push_back(w);
    endtask

    task automatic push_random(int count);
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        for (int i = 0; i < count; i++)
        begin
            num = rand_operand();
            case ($urandom_range(0, 39))
                0:
                begin
                    den = '0;
                end
                1:
                begin
                    num = MOST_NEG;
                    den = MINUS_ONE;
                end
                2:
                begin
                    // equal magnitudes, either sign
                    den = $urandom_range(0, 1) ? -num : num;
                end
                default:
                begin
                    den = rand_operand();
                end
            endcase
            push_word(num, den);
        end
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || req_if.valid || quotient_q.size() != 0);
    endtask

    // reset and stimulus
    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 54;

        // zero denominator, any numerator
        push_word(0, 0);
        push_word(MOST_NEG, 0);
        push_word(MOST_POS, 0);
        push_word(-5, 0);
        // saturation and the most negative operand elsewhere
        push_word(MOST_NEG, MINUS_ONE);
        push_word(MOST_NEG, 1);
        push_word(MOST_NEG, 2);
        push_word(MOST_NEG, -2);
        push_word(MOST_NEG, MOST_NEG);
        push_word(MOST_NEG, MOST_POS);
        push_word(MOST_POS, MOST_NEG);
        push_word(-1, MOST_NEG);
        push_word(MOST_POS, MOST_POS);
        push_word(MOST_POS, 1);
        push_word(MOST_POS, MINUS_ONE);
        push_word(1, MOST_POS);
        // sign combinations and truncation
        push_word(7, 2);
        push_word(-7, 2);
        push_word(7, -2);
        push_word(-7, -2);
        push_word(-1, -1);
        push_word(0, -5);
        // equal magnitudes with mixed signs
        push_word(12, 12);
        push_word(-12, 12);
        push_word(12, -12);

        push_random(RAND_WORDS);
        wait_drained();

        send_idle_pct = 54;
        recv_idle_pct = 37;
        push_random(RAND_WORDS);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(RAND_WORDS);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_cnt == 0)
            $display("PASS signed_integer_divider");
        else
            $display("FAIL signed_integer_divider");
        $finish;
    end

    // input driver, records the expected result of each accepted word
    always @(posedge clk)
    begin : drive_words
        div_word_t nxt;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                quotient_q.push_back(predict_quotient(req_if.numerator, req_if.denominator));
                words_sent++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_q.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.numerator   <= nxt.num;
                    req_if.denominator <= nxt.den;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // output ready, with one long hold-off so the block backs up its input
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            rsp_if.ready <= 1'b0;
            hold_cnt     <= hold_cnt - 1;
        end
        else if (!hold_done && words_sent >= 40)
        begin
            rsp_if.ready <= 1'b0;
            hold_cnt     <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else
        begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin : check_results
        div_result_t exp_res;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (quotient_q.size() == 0)
            begin
                $error("unexpected word: quotient %0d status %0d",
                       $signed(rsp_if.quotient), rsp_if.status);
                fail_cnt++;
            end
            else
            begin
                exp_res = quotient_q.pop_front();
                if (rsp_if.quotient !== exp_res.quotient)
                begin
                    $error("quotient: expected %0d, got %0d",
                           $signed(exp_res.quotient), $signed(rsp_if.quotient));
                    fail_cnt++;
                end
                if (rsp_if.status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, rsp_if.status);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no word accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL signed_integer_divider");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
sv/sid_pkg.sv
sv/sid_if.sv
sv/sid_ctrl.sv
sv/sid_dp.sv
sv/signed_integer_divider.sv
test/tb_signed_integer_divider.sv
